@@ rtl/core/chacha8_pkg.sv @@
// Shared types, constants and helper functions of the ChaCha8 counter generator.
package chacha8_pkg;

  localparam int unsigned NumKeyRegs = 4;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [1:0] FuncWord32 = 2'd0;
  localparam logic [1:0] FuncWord64 = 2'd1;
  localparam logic [1:0] FuncBelow  = 2'd2;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone      = 4'd0,
    OpInitBlock = 4'd1,
    OpQuarter   = 4'd2,
    OpFinish    = 4'd3,
    OpTakeWord  = 4'd4,
    OpModStart  = 4'd5,
    OpModStep   = 4'd6,
    OpZeroRes   = 4'd7,
    OpBadRes    = 4'd8,
    OpLoadRes   = 4'd9,
    OpModRes    = 4'd10
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] qsel;      // which of the eight quarter rounds
    logic       word_slot; // 0: low half of gathered word, 1: high half
    logic       min_pass;  // remainder pass computes the rejection minimum
    logic       low_only;  // result keeps only the low half, zero-extended
  } dp_cmd_t;

  typedef struct packed {
    logic       buf_empty;
    logic       mod_done;
    logic       reject;    // gathered value below the minimum
  } dp_status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    rotl32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [127:0] quarter_round(input logic [127:0] abcd);
    logic [31:0] a, b, c, d;
    a = abcd[127:96]; b = abcd[95:64]; c = abcd[63:32]; d = abcd[31:0];
    a = a + b; d = rotl32(d ^ a, 16);
    c = c + d; b = rotl32(b ^ c, 12);
    a = a + b; d = rotl32(d ^ a, 8);
    c = c + d; b = rotl32(b ^ c, 7);
    quarter_round = {a, b, c, d};
  endfunction

endpackage

@@ rtl/core/chacha8_datapath.sv @@
// Datapath: key store, cipher state, word buffer, remainder unit, result register.
module chacha8_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [63:0]                cfg_data_i,
  input  logic [63:0]                bound_i,
  input  chacha8_pkg::dp_cmd_t       cmd_i,
  output chacha8_pkg::dp_status_t    status_o,
  output logic [63:0]                value_o,
  output logic                       bad_bound_o
);
  import chacha8_pkg::*;

  logic [63:0]  key_q [NumKeyRegs];
  logic [63:0]  ctr_q;
  logic [3:0]   left_q;
  logic [31:0]  st_q [16];
  logic [31:0]  blk_q [16];
  logic [63:0]  gath_q;
  logic [63:0]  bound_q;
  logic [63:0]  min_q;
  logic [63:0]  rem_q;
  logic [63:0]  dvd_q;
  logic [6:0]   bit_q;
  logic [63:0]  value_q;
  logic         bad_q;

  logic [31:0]  word;
  logic [3:0]   qa, qb, qc, qd;
  logic [127:0] qout;
  logic [64:0]  rem_sh;
  logic [64:0]  rem_sub;

  // Quarter-round lane selection: four column rounds then four diagonals
  always_comb begin
    qa = {2'b00, cmd_i.qsel[1:0]};
    if (!cmd_i.qsel[2]) begin
      qb = 4'd4 + {2'b00, cmd_i.qsel[1:0]};
      qc = 4'd8 + {2'b00, cmd_i.qsel[1:0]};
      qd = 4'd12 + {2'b00, cmd_i.qsel[1:0]};
    end else begin
      qb = 4'd4 + {2'b00, cmd_i.qsel[1:0] + 2'd1};
      qc = 4'd8 + {2'b00, cmd_i.qsel[1:0] + 2'd2};
      qd = 4'd12 + {2'b00, cmd_i.qsel[1:0] + 2'd3};
    end
    qout = quarter_round({st_q[qa], st_q[qb], st_q[qc], st_q[qd]});
  end

  // Next word out of the buffer (after a refill word 15 comes first)
  assign word = blk_q[left_q - 4'd1];

  // Restoring remainder step, one dividend bit per cycle
  assign rem_sh  = {rem_q, dvd_q[63]};
  assign rem_sub = rem_sh - {1'b0, bound_q};

  assign status_o.buf_empty = (left_q == 4'd0);
  assign status_o.mod_done  = (bit_q == 7'd0);
  assign status_o.reject    = (gath_q < min_q);

  // Key registers and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeyRegs; i++) key_q[i] <= '0;
      ctr_q  <= '0;
      left_q <= '0;
    end else if (cfg_valid_i) begin
      key_q[cfg_index_i] <= cfg_data_i;
      ctr_q  <= '0;
      left_q <= '0;
    end else if (cmd_i.op == OpFinish) begin
      ctr_q  <= ctr_q + 64'd1;
      left_q <= 4'd0; // first take wraps to word 15 and leaves 15 buffered
    end else if (cmd_i.op == OpTakeWord) begin
      left_q <= left_q - 4'd1;
    end
  end

  // Cipher working state and output block
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpInitBlock: begin
        st_q[0] <= Sigma0; st_q[1] <= Sigma1; st_q[2] <= Sigma2; st_q[3] <= Sigma3;
        for (int i = 0; i < 4; i++) begin
          st_q[4 + 2 * i] <= key_q[i][31:0];
          st_q[5 + 2 * i] <= key_q[i][63:32];
        end
        st_q[12] <= ctr_q[31:0];
        st_q[13] <= ctr_q[63:32];
        st_q[14] <= '0;
        st_q[15] <= '0;
      end
      OpQuarter: begin
        st_q[qa] <= qout[127:96];
        st_q[qb] <= qout[95:64];
        st_q[qc] <= qout[63:32];
        st_q[qd] <= qout[31:0];
      end
      OpFinish: begin
        blk_q[0] <= st_q[0] + Sigma0; blk_q[1] <= st_q[1] + Sigma1;
        blk_q[2] <= st_q[2] + Sigma2; blk_q[3] <= st_q[3] + Sigma3;
        for (int i = 0; i < 4; i++) begin
          blk_q[4 + 2 * i] <= st_q[4 + 2 * i] + key_q[i][31:0];
          blk_q[5 + 2 * i] <= st_q[5 + 2 * i] + key_q[i][63:32];
        end
        blk_q[12] <= st_q[12] + ctr_q[31:0];
        blk_q[13] <= st_q[13] + ctr_q[63:32];
        blk_q[14] <= st_q[14];
        blk_q[15] <= st_q[15];
      end
      default: ;
    endcase
  end

  // Word gathering, remainder unit and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else begin
      case (cmd_i.op)
        OpModStart: begin
          bit_q <= 7'd64;
        end
        OpModStep: begin
          bit_q <= bit_q - 7'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpTakeWord: begin
        if (cmd_i.word_slot) gath_q[63:32] <= word;
        else                 gath_q[31:0]  <= word;
      end
      OpModStart: begin
        rem_q   <= '0;
        if (cmd_i.min_pass) begin
          // bound is captured once, at acceptance of the request
          bound_q <= bound_i;
          dvd_q   <= 64'd0 - bound_i;
          min_q   <= '0;
        end else begin
          dvd_q <= gath_q;
        end
      end
      OpModStep: begin
        if (!rem_sub[64]) rem_q <= rem_sub[63:0];
        else              rem_q <= rem_sh[63:0];
        dvd_q <= {dvd_q[62:0], 1'b0};
        if (cmd_i.min_pass && bit_q == 7'd1) begin
          min_q <= (!rem_sub[64]) ? rem_sub[63:0] : rem_sh[63:0];
        end
      end
      OpZeroRes: begin value_q <= '0; bad_q <= 1'b0; end
      OpBadRes:  begin value_q <= '0; bad_q <= 1'b1; end
      OpLoadRes: begin
        value_q <= cmd_i.low_only ? {32'h0, gath_q[31:0]} : gath_q;
        bad_q   <= 1'b0;
      end
      OpModRes:  begin value_q <= rem_q; bad_q <= 1'b0; end
      default: ;
    endcase
  end

  assign value_o     = value_q;
  assign bad_bound_o = bad_q;

endmodule

@@ rtl/core/chacha8_ctrl.sv @@
// Controller: sequences refills, word draws, remainder passes and result hand-off.
module chacha8_ctrl #(
  parameter int unsigned DOUBLE_ROUNDS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              func_i,
  input  logic [63:0]             bound_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  chacha8_pkg::dp_status_t status_i,
  output chacha8_pkg::dp_cmd_t    cmd_o
);
  import chacha8_pkg::*;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StMin    = 9'b000000010,
    StFetch  = 9'b000000100,
    StRound  = 9'b000001000,
    StFinish = 9'b000010000,
    StTake   = 9'b000100000,
    StCheck  = 9'b001000000,
    StMod    = 9'b010000000,
    StOut    = 9'b100000000
  } state_e;

  localparam int unsigned RndW = $clog2(DOUBLE_ROUNDS * 8);

  state_e         state_q, state_d;
  logic [1:0]     func_q, func_d;
  logic           slot_q, slot_d;   // word position in current draw
  logic           second_q, second_d; // second word of current draw pending
  logic [RndW-1:0] rnd_q, rnd_d;
  logic           out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    slot_d      = slot_q;
    second_d    = second_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q;
    cmd_o       = '{op: OpNone, qsel: rnd_q[2:0], word_slot: slot_q,
                    min_pass: (state_q == StMin), low_only: 1'b0};
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && (!out_valid_q || out_ready_i)) begin
          func_d = func_i;
          case (func_i)
            FuncWord32: begin
              slot_d = 1'b0; second_d = 1'b0; state_d = StFetch;
            end
            FuncWord64: begin
              slot_d = 1'b1; second_d = 1'b1; state_d = StFetch;
            end
            FuncBelow: begin
              if (bound_i == 64'd0) begin
                cmd_o.op = OpBadRes; out_valid_d = 1'b1;
              end else begin
                cmd_o.op = OpModStart; cmd_o.min_pass = 1'b1; state_d = StMin;
              end
            end
            default: begin
              cmd_o.op = OpZeroRes; out_valid_d = 1'b1;
            end
          endcase
        end
      end
      StMin: begin
        cmd_o.op = OpModStep;
        if (status_i.mod_done) begin
          cmd_o.op = OpNone; slot_d = 1'b0; second_d = 1'b1; state_d = StFetch;
        end
      end
      StFetch: begin
        if (status_i.buf_empty) begin
          cmd_o.op = OpInitBlock; rnd_d = '0; state_d = StRound;
        end else begin
          state_d = StTake;
        end
      end
      StRound: begin
        cmd_o.op = OpQuarter;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RndW'(DOUBLE_ROUNDS * 8 - 1)) state_d = StFinish;
      end
      StFinish: begin
        cmd_o.op = OpFinish; state_d = StTake;
      end
      StTake: begin
        cmd_o.op = OpTakeWord;
        if (second_q) begin
          second_d = 1'b0; slot_d = ~slot_q; state_d = StFetch;
        end else begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (func_q != FuncBelow) begin
          cmd_o.op = OpLoadRes; cmd_o.low_only = (func_q == FuncWord32); state_d = StOut;
        end else if (status_i.reject) begin
          slot_d = 1'b0; second_d = 1'b1; state_d = StFetch;
        end else begin
          cmd_o.op = OpModStart; state_d = StMod;
        end
      end
      StMod: begin
        cmd_o.op = OpModStep;
        if (status_i.mod_done) begin
          cmd_o.op = OpModRes; state_d = StOut;
        end
      end
      StOut: begin
        out_valid_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      func_q      <= '0;
      slot_q      <= 1'b0;
      second_q    <= 1'b0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      slot_q      <= slot_d;
      second_q    <= second_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/chacha8_counter_prng_core.sv @@
// Top level of the ChaCha8 counter-mode random number generator.
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_ready_o   func_i, bound_i
//  out      output     out_valid_o/out_ready_i value_o, bad_bound_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// A 32-bit request draws one buffered word and a 64-bit one two; an empty buffer is
// refilled at one quarter round per cycle. A bounded request adds two remainder
// passes (one bit per cycle), plus a two-word redraw per rejection. Reset empties
// the buffer and clears the key and counter. A waiting result holds off only the
// next request.
module chacha8_counter_prng_core #(
  parameter int unsigned DOUBLE_ROUNDS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] bound_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic        bad_bound_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import chacha8_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  chacha8_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .bound_i,
    .out_valid_o, .out_ready_i, .status_i(status), .cmd_o(cmd)
  );

  chacha8_datapath u_dp (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .bound_i,
    .cmd_i(cmd), .status_o(status), .value_o, .bad_bound_o
  );
endmodule

@@ bench/chacha8_counter_prng_core_test.sv @@
// Self-checking bench for the ChaCha8 counter generator: predicts each request's result and compares it.
module chacha8_counter_prng_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import chacha8_pkg::*;

  localparam int unsigned Rounds = 4;
  localparam longint unsigned CycleLimit = 3_000_000;

  // expected result of one request
  typedef struct packed {
    logic [63:0] value;
    logic        bad;
  } prng_res_t;

  // scoreboard: software copy of the generator plus the queue of pending results
  class prng_scoreboard;
    logic [63:0] keys[4];
    logic [31:0] blk[16];
    logic [3:0]  left;
    logic [63:0] ctr;
    prng_res_t   pending[$];
    int          mismatches;
    int          checked;

    function void clear_state();
      foreach (keys[i]) keys[i] = '0;
      foreach (blk[i]) blk[i] = '0;
      left = '0;
      ctr = '0;
    endfunction

    function void set_key(int idx, logic [63:0] data);
      keys[idx] = data;
      ctr = '0;
      left = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    // one quarter round on words a, b, c, d of the working block
    function void qr(ref logic [31:0] s[16], input int a, int b, int c, int d);
      s[a] = s[a] + s[b]; s[d] = rol(s[d] ^ s[a], 16);
      s[c] = s[c] + s[d]; s[b] = rol(s[b] ^ s[c], 12);
      s[a] = s[a] + s[b]; s[d] = rol(s[d] ^ s[a], 8);
      s[c] = s[c] + s[d]; s[b] = rol(s[b] ^ s[c], 7);
    endfunction

    // compute the next cipher block and advance the counter
    function void make_block();
      logic [31:0] init[16];
      logic [31:0] s[16];
      init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
      for (int i = 0; i < 4; i++) begin
        init[4 + 2 * i] = keys[i][31:0];
        init[5 + 2 * i] = keys[i][63:32];
      end
      init[12] = ctr[31:0];
      init[13] = ctr[63:32];
      init[14] = '0;
      init[15] = '0;
      s = init;
      for (int r = 0; r < Rounds; r++) begin
        qr(s, 0, 4, 8, 12); qr(s, 1, 5, 9, 13); qr(s, 2, 6, 10, 14); qr(s, 3, 7, 11, 15);
        qr(s, 0, 5, 10, 15); qr(s, 1, 6, 11, 12); qr(s, 2, 7, 8, 13); qr(s, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) blk[i] = s[i] + init[i];
      ctr = ctr + 64'd1;
    endfunction

    function logic [31:0] draw_word();
      if (left != 4'd0) begin
        left = left - 4'd1;
        return blk[left];
      end
      make_block();
      left = 4'd15;
      return blk[15];
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(logic [1:0] func, logic [63:0] bound);
      prng_res_t res;
      logic [63:0] hi, lo, r, floor_val;
      res = '0;
      if (func == FuncWord32) begin
        res.value = {32'h0, draw_word()};
      end else if (func == FuncWord64) begin
        hi = {32'h0, draw_word()};
        lo = {32'h0, draw_word()};
        res.value = (hi << 32) | lo;
      end else if (func == FuncBelow) begin
        if (bound == 0) begin
          res.bad = 1'b1;
        end else begin
          floor_val = (64'h0 - bound) % bound;
          do begin
            lo = {32'h0, draw_word()};
            hi = {32'h0, draw_word()};
            r = lo | (hi << 32);
          end while (r < floor_val);
          res.value = r % bound;
        end
      end
      pending.push_back(res);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [63:0] value, logic bad);
      prng_res_t exp_res;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h bad=%b", value, bad);
        return;
      end
      exp_res = pending.pop_front();
      if (value !== exp_res.value || bad !== exp_res.bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected value=%h bad=%b, got value=%h bad=%b",
                   checked, exp_res.value, exp_res.bad, value, bad);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [63:0] bound_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] value_o;
  logic        bad_bound_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  chacha8_counter_prng_core #(.DOUBLE_ROUNDS(Rounds)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .bound_i,
    .out_valid_o, .out_ready_i, .value_o, .bad_bound_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  prng_scoreboard sb;
  int  send_idle_pct;
  int  stall_pct;
  bit  hold_off;
  int  requests;
  longint unsigned cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stall, long hold-off on request
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_result(value_o, bad_bound_o);
    out_ready_i <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // one register write, after which valid is dropped and the channel idles
  task automatic write_key(int idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[1:0];
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_key(idx, data);
    @(posedge clk_i);
  endtask

  // offer one request and wait for its acceptance; valid stays up for the caller
  task automatic send_request(logic [1:0] func, logic [63:0] bound);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    bound_i    <= bound;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(func, bound);
    requests++;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random bound: mostly small, sometimes wide or near the rejection worst case
  function automatic logic [63:0] rand_bound();
    case ($urandom_range(5))
      0: return $urandom_range(20);
      1: return rand64();
      2: return 64'h8000_0000_0000_0000 + $urandom_range(1000);
      3: return rand64() >> $urandom_range(63);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_requests(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k < 4) send_request(FuncWord32, rand64());
      else if (k < 7) send_request(FuncWord64, rand64());
      else if (k < 9) send_request(FuncBelow, rand_bound());
      else send_request(2'($urandom_range(3)), $urandom_range(1) ? 64'h0 : rand64());
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    cycles = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    requests = 0;
    in_valid_i = 1'b0; func_i = '0; bound_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero key, every kind, bound extremes, unknown kind
    send_request(FuncWord32, '0);
    send_request(FuncWord64, '1);
    send_request(FuncBelow, 64'd0);
    send_request(FuncBelow, 64'd1);
    send_request(FuncBelow, 64'd2);
    send_request(FuncBelow, 64'd3);
    send_request(FuncBelow, 64'h8000_0000_0000_0001);
    send_request(FuncBelow, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FuncBelow, 64'h5555_5555_5555_5555);
    send_request(FuncBelow, 64'h1_0000_0000);
    send_request(2'd3, '1);
    for (int i = 0; i < 12; i++) send_request(FuncWord32, '0);
    in_valid_i <= 1'b0;
    drain();

    // all-ones key, then mixed keys across idling phases
    for (int i = 0; i < 4; i++) write_key(i, '1);
    random_requests(60);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 66 : 32) : 0;
      stall_pct     = (ph == 2 || ph == 3) ? (ph == 2 ? 66 : 32) : 0;
      write_key($urandom_range(3), rand64());
      if (ph == 0) write_key(0, '0);
      random_requests(400);
      drain();
    end

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_requests(60);
    join
    drain();

    for (int i = 0; i < 4; i++) write_key(i, rand64());
    random_requests(250);
    drain();

    $display("ran %0d requests across several keys, four idle phases and a long hold-off,",
             requests);
    $display("%0d results checked", sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

@@ chacha8_counter_prng_core.f @@
rtl/core/chacha8_pkg.sv
rtl/core/chacha8_datapath.sv
rtl/core/chacha8_ctrl.sv
rtl/core/chacha8_counter_prng_core.sv
bench/chacha8_counter_prng_core_test.sv
